[sv/touch_report_event_decoder_macros.svh]
// Assertion macros used by the touch report decoder sequencer, trd_ctrl.
// Depends on nothing; files that assert include it by name.
`ifndef TOUCH_REPORT_EVENT_DECODER_MACROS_SVH
`define TOUCH_REPORT_EVENT_DECODER_MACROS_SVH

// Antecedent implies consequent in the same cycle.
`define TRD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("touch decoder check failed: same-cycle implication");

// Antecedent implies consequent in the next cycle.
`define TRD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("touch decoder check failed: next-cycle implication");

`endif

[sv/trd_pkg.sv]
// Shared constants, codes and interface types of the touch report decoder.
// Depends on nothing; the design files and the testbench refer to it by scoped names.
package trd_pkg;

   localparam int SCREEN_WIDTH  = 176;
   localparam int SCREEN_HEIGHT = 176;
   localparam int SCREEN_MAX    = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
   localparam int SIZE_W        = $clog2(SCREEN_MAX + 1);

   localparam logic [7:0] RAW_LIMIT     = 8'd250;
   localparam logic [7:0] TAP_SPLIT     = 8'd80;
   localparam logic [7:0] CAL_MAX_RESET = 8'd160;

   // Gesture codes of the controller.
   localparam logic [7:0] GEST_DOWN   = 8'h01;
   localparam logic [7:0] GEST_UP     = 8'h02;
   localparam logic [7:0] GEST_LEFT   = 8'h03;
   localparam logic [7:0] GEST_RIGHT  = 8'h04;
   localparam logic [7:0] GEST_CLICK  = 8'h05;
   localparam logic [7:0] GEST_DOUBLE = 8'h0B;
   localparam logic [7:0] GEST_LONG   = 8'h0C;

   localparam logic [1:0] TAP_CLICK  = 2'd0;
   localparam logic [1:0] TAP_DOUBLE = 2'd1;
   localparam logic [1:0] TAP_LONG   = 2'd2;

   // Divider sizing: the numerator magnitude is at most 255 * SCREEN_MAX and the
   // divider retires two quotient bits per step.
   localparam int NUM_W     = 8 + $clog2(SCREEN_MAX);
   localparam int DIV_STEPS = (NUM_W + 1) / 2;
   localparam int DIV_W     = 2 * DIV_STEPS;
   localparam int CNT_W     = $clog2(DIV_STEPS);
   localparam int SV_W      = DIV_W + 2;

   localparam int CSR_ADDR_W = 5;

   typedef enum logic [2:0] {
      REG_CAL_MIN_X   = 3'd0,
      REG_CAL_MIN_Y   = 3'd1,
      REG_CAL_MAX_X   = 3'd2,
      REG_CAL_MAX_Y   = 3'd3,
      REG_ORIENTATION = 3'd4,
      REG_LOCKED      = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [7:0] cal_min_x;
      logic [7:0] cal_min_y;
      logic [7:0] cal_max_x;
      logic [7:0] cal_max_y;
      logic [2:0] orientation;
      logic       locked;
   } cfg_type;

   typedef struct packed {
      logic capture;
      logic load;
      logic axis_y;
      logic step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic div_last;
   } status_type;

endpackage

[sv/trd_ctrl.sv]
// Sequencer of the touch report decoder: input handshake, divider steps, result slot.
// Depends on trd_pkg and the assertion macros header.
`include "touch_report_event_decoder_macros.svh"

module trd_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  trd_pkg::status_type status,
   output trd_pkg::cmd_type    cmd
);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOAD_X = 6'b000010,
      S_DIV_X  = 6'b000100,
      S_LOAD_Y = 6'b001000,
      S_DIV_Y  = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOAD_X;
            end
         end
         S_LOAD_X: begin
            cmd.load = 1'b1;
            state_in = S_DIV_X;
         end
         S_DIV_X: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = S_LOAD_Y;
            end
         end
         S_LOAD_Y: begin
            cmd.load   = 1'b1;
            cmd.axis_y = 1'b1;
            state_in   = S_DIV_Y;
         end
         S_DIV_Y: begin
            cmd.step   = 1'b1;
            cmd.axis_y = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            // The result register must be empty or emptying this cycle.
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.commit = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

   `TRD_ASSERT_NOW(a_commit_slot_free, clock, reset, cmd.commit, (!rsp_valid_ff || rsp_ready))
   `TRD_ASSERT_NEXT(a_commit_shows_beat, clock, reset, cmd.commit, rsp_valid_ff)
   `TRD_ASSERT_NEXT(a_accept_starts_x, clock, reset, (req_valid && req_ready), (state_ff == S_LOAD_X))
   `TRD_ASSERT_NOW(a_step_excludes_load, clock, reset, cmd.step, (!cmd.load && !cmd.capture))

endmodule

[sv/trd_dp.sv]
// Datapath of the touch report decoder: report latch, shared radix-4 divider,
// orientation, event decode, drag state and the result register.
// Depends on trd_pkg.
module trd_dp (
   input  logic                clock,
   input  logic                reset,
   input  trd_pkg::cfg_type    cfg,
   input  trd_pkg::cmd_type    cmd,
   output trd_pkg::status_type status,
   input  logic [7:0]          req_gesture_code,
   input  logic [7:0]          req_touch_points,
   input  logic [7:0]          req_raw_x,
   input  logic [7:0]          req_raw_y,
   output logic                rsp_swipe_valid,
   output logic signed [1:0]   rsp_swipe_dx,
   output logic signed [1:0]   rsp_swipe_dy,
   output logic                rsp_tap_left,
   output logic                rsp_tap_right,
   output logic [1:0]          rsp_tap_kind,
   output logic                rsp_drag_valid,
   output logic [7:0]          rsp_pos_x,
   output logic [7:0]          rsp_pos_y,
   output logic                rsp_pressed,
   output logic signed [8:0]   rsp_drag_dx,
   output logic signed [8:0]   rsp_drag_dy
);

   localparam int DIV_W  = trd_pkg::DIV_W;
   localparam int SV_W   = trd_pkg::SV_W;
   localparam int CNT_W  = trd_pkg::CNT_W;
   localparam int SIZE_W = trd_pkg::SIZE_W;

   localparam logic [SIZE_W-1:0] WIDTH_C  = SIZE_W'(trd_pkg::SCREEN_WIDTH);
   localparam logic [SIZE_W-1:0] HEIGHT_C = SIZE_W'(trd_pkg::SCREEN_HEIGHT);

   // Latched report.
   logic [7:0] gest_ff, pts_ff, rx_ff, ry_ff;

   // Divider.
   logic [DIV_W-1:0] num_ff, num_in, quo_ff, quo_in;
   logic [7:0]       rem_ff, rem_in, den_ff;
   logic             neg_ff, zero_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic signed [SV_W-1:0] sx_ff, sy_ff, s_res;

   // Persistent decode state.
   logic [7:0] prev_gest_ff, last_x_ff, last_y_ff;
   logic       last_pr_ff;

   // Operand preparation for the selected axis.
   logic [7:0]        ld_raw, ld_lo, ld_hi, ld_eff, diff_mag, den_mag;
   logic [SIZE_W-1:0] ld_size;
   logic signed [8:0] diff, span;
   logic [DIV_W-1:0]  num_load;

   always_comb begin
      ld_raw   = cmd.axis_y ? ry_ff : rx_ff;
      ld_lo    = cmd.axis_y ? cfg.cal_min_y : cfg.cal_min_x;
      ld_hi    = cmd.axis_y ? cfg.cal_max_y : cfg.cal_max_x;
      ld_size  = cmd.axis_y ? HEIGHT_C : WIDTH_C;
      ld_eff   = (ld_raw >= trd_pkg::RAW_LIMIT) ? 8'd0 : ld_raw;
      diff     = $signed({1'b0, ld_eff}) - $signed({1'b0, ld_lo});
      span     = $signed({1'b0, ld_hi}) - $signed({1'b0, ld_lo});
      diff_mag = diff[8] ? 8'(-diff) : diff[7:0];
      den_mag  = span[8] ? 8'(-span) : span[7:0];
      num_load = DIV_W'(DIV_W'(diff_mag) * DIV_W'(ld_size));
   end

   // Two restoring division steps per cycle.
   always_comb begin
      logic [8:0] trial;
      num_in = num_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      for (int i = 0; i < 2; i++) begin
         trial  = {rem_in, num_in[DIV_W-1]};
         num_in = {num_in[DIV_W-2:0], 1'b0};
         if (trial >= {1'b0, den_ff}) begin
            rem_in = 8'(trial - {1'b0, den_ff});
            quo_in = {quo_in[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = trial[7:0];
            quo_in = {quo_in[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_comb begin
      logic signed [SV_W-1:0] q_s;
      q_s = $signed(SV_W'(quo_in));
      if (zero_ff) begin
         s_res = '0;
      end else if (neg_ff) begin
         s_res = -q_s;
      end else begin
         s_res = q_s;
      end
   end

   assign status.div_last = (cnt_ff == CNT_W'(trd_pkg::DIV_STEPS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.load) begin
         cnt_ff <= '0;
      end else if (cmd.step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         gest_ff <= req_gesture_code;
         pts_ff  <= req_touch_points;
         rx_ff   <= req_raw_x;
         ry_ff   <= req_raw_y;
      end
      if (cmd.load) begin
         num_ff  <= num_load;
         quo_ff  <= '0;
         rem_ff  <= '0;
         den_ff  <= den_mag;
         neg_ff  <= diff[8] ^ span[8];
         zero_ff <= (span == 9'sd0);
      end else if (cmd.step) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
         rem_ff <= rem_in;
         if (status.div_last) begin
            if (cmd.axis_y) begin
               sy_ff <= s_res;
            end else begin
               sx_ff <= s_res;
            end
         end
      end
   end

   // Orientation, saturation and event decode of the finished report.
   function automatic logic [7:0] clamp_axis(input logic signed [SV_W-1:0] v,
                                             input logic [SIZE_W-1:0] size);
      logic signed [SV_W-1:0] lim;
      lim = $signed(SV_W'(size)) - SV_W'(1);
      if (v < 0) begin
         return 8'd0;
      end else if (v > lim) begin
         return 8'(lim);
      end
      return 8'(v);
   endfunction

   logic signed [SV_W-1:0] ox, oy, tx, ty;
   logic [7:0]        px, py;
   logic              pr, sv, tl, tr, dv;
   logic signed [1:0] sdx, sdy, rdx, rdy;
   logic [1:0]        kind;
   logic signed [8:0] ddx, ddy;

   always_comb begin
      tx = cfg.orientation[0] ? ($signed(SV_W'(WIDTH_C)) - SV_W'(1) - sx_ff) : sx_ff;
      ty = cfg.orientation[1] ? ($signed(SV_W'(HEIGHT_C)) - SV_W'(1) - sy_ff) : sy_ff;
      ox = cfg.orientation[2] ? ty : tx;
      oy = cfg.orientation[2] ? tx : ty;
      px = clamp_axis(ox, WIDTH_C);
      py = clamp_axis(oy, HEIGHT_C);
      pr = (pts_ff != 8'd0);

      sv   = 1'b0;
      tl   = 1'b0;
      tr   = 1'b0;
      kind = trd_pkg::TAP_CLICK;
      sdx  = 2'sd0;
      sdy  = 2'sd0;
      if (gest_ff != prev_gest_ff) begin
         case (gest_ff) inside
            trd_pkg::GEST_DOWN: begin
               sv  = 1'b1;
               sdy = 2'sd1;
            end
            trd_pkg::GEST_UP: begin
               sv  = 1'b1;
               sdy = -2'sd1;
            end
            trd_pkg::GEST_LEFT: begin
               sv  = 1'b1;
               sdx = -2'sd1;
            end
            trd_pkg::GEST_RIGHT: begin
               sv  = 1'b1;
               sdx = 2'sd1;
            end
            trd_pkg::GEST_CLICK, trd_pkg::GEST_DOUBLE, trd_pkg::GEST_LONG: begin
               tl = (px < trd_pkg::TAP_SPLIT);
               tr = !(px < trd_pkg::TAP_SPLIT);
               if (gest_ff == trd_pkg::GEST_DOUBLE) begin
                  kind = trd_pkg::TAP_DOUBLE;
               end else if (gest_ff == trd_pkg::GEST_LONG) begin
                  kind = trd_pkg::TAP_LONG;
               end
            end
            default: begin
            end
         endcase
      end
      // Swipe directions turn with the screen.
      if (cfg.orientation[0]) begin
         sdx = -sdx;
      end
      if (cfg.orientation[1]) begin
         sdy = -sdy;
      end
      rdx = cfg.orientation[2] ? sdy : sdx;
      rdy = cfg.orientation[2] ? sdx : sdy;

      dv  = (pr != last_pr_ff) || (px != last_x_ff) || (py != last_y_ff);
      ddx = 9'sd0;
      ddy = 9'sd0;
      if (dv && last_pr_ff) begin
         ddx = $signed({1'b0, px}) - $signed({1'b0, last_x_ff});
         ddy = $signed({1'b0, py}) - $signed({1'b0, last_y_ff});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_gest_ff <= '0;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         last_pr_ff   <= 1'b0;
      end else if (cmd.commit && !cfg.locked) begin
         prev_gest_ff <= gest_ff;
         if (dv) begin
            last_x_ff  <= px;
            last_y_ff  <= py;
            last_pr_ff <= pr;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         if (cfg.locked) begin
            rsp_swipe_valid <= 1'b0;
            rsp_swipe_dx    <= 2'sd0;
            rsp_swipe_dy    <= 2'sd0;
            rsp_tap_left    <= 1'b0;
            rsp_tap_right   <= 1'b0;
            rsp_tap_kind    <= trd_pkg::TAP_CLICK;
            rsp_drag_valid  <= 1'b0;
            rsp_pos_x       <= 8'd0;
            rsp_pos_y       <= 8'd0;
            rsp_pressed     <= 1'b0;
            rsp_drag_dx     <= 9'sd0;
            rsp_drag_dy     <= 9'sd0;
         end else begin
            rsp_swipe_valid <= sv;
            rsp_swipe_dx    <= rdx;
            rsp_swipe_dy    <= rdy;
            rsp_tap_left    <= tl;
            rsp_tap_right   <= tr;
            rsp_tap_kind    <= kind;
            rsp_drag_valid  <= dv;
            rsp_pos_x       <= px;
            rsp_pos_y       <= py;
            rsp_pressed     <= pr;
            rsp_drag_dx     <= ddx;
            rsp_drag_dy     <= ddy;
         end
      end
   end

endmodule

[sv/touch_report_event_decoder.sv]
// Top level of the touch report decoder: register port, sequencer and datapath.
// Depends on trd_pkg, trd_ctrl and trd_dp.
//
// One report beat in gives exactly one result beat out. A report is taken
// only while the block is idle: it is latched, then loaded and divided for
// X, then loaded and divided for Y, and then committed to the result
// register, and the next report can be taken only after that. These steps
// are paced by the single shared divider, which works through
// the X scaling and then the Y scaling, retiring two quotient bits per cycle
// over a 16-bit numerator. The result sits in an output register, so the next
// report is taken as soon as the previous one has been written there, even if
// the downstream side has not yet taken it. Raw coordinates of 250 or more
// read as zero; each axis is scaled from its calibration window to the screen
// (a zero-width window gives 0), then inverted, swapped and saturated as the
// orientation register says. A gesture code that differs from the previous
// report's code yields a swipe (rotated with the orientation) or a left/right
// tap; a change of position or press state yields a drag with its delta.
// While the locked bit is set every result field is zero and no history is
// kept. Registers sit at byte addresses 0x00 cal_min_x, 0x04 cal_min_y,
// 0x08 cal_max_x, 0x0C cal_max_y, 0x10 orientation and 0x14 locked; write
// them only while no report is in flight.
module touch_report_event_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [7:0]                       req_gesture_code,
   input  logic [7:0]                       req_touch_points,
   input  logic [7:0]                       req_raw_x,
   input  logic [7:0]                       req_raw_y,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic                             rsp_swipe_valid,
   output logic signed [1:0]                rsp_swipe_dx,
   output logic signed [1:0]                rsp_swipe_dy,
   output logic                             rsp_tap_left,
   output logic                             rsp_tap_right,
   output logic [1:0]                       rsp_tap_kind,
   output logic                             rsp_drag_valid,
   output logic [7:0]                       rsp_pos_x,
   output logic [7:0]                       rsp_pos_y,
   output logic                             rsp_pressed,
   output logic signed [8:0]                rsp_drag_dx,
   output logic signed [8:0]                rsp_drag_dy,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [trd_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [31:0]                      csr_pwdata,
   output logic [31:0]                      csr_prdata,
   output logic                             csr_pready
);

   trd_pkg::cfg_type       cfg_ff;
   trd_pkg::cmd_type       cmd;
   trd_pkg::status_type    status;
   trd_pkg::reg_index_type reg_sel;
   logic                   csr_write;

   // Registers are word aligned; the two low address bits are ignored.
   assign reg_sel    = trd_pkg::reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite;
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.cal_min_x   <= 8'd0;
         cfg_ff.cal_min_y   <= 8'd0;
         cfg_ff.cal_max_x   <= trd_pkg::CAL_MAX_RESET;
         cfg_ff.cal_max_y   <= trd_pkg::CAL_MAX_RESET;
         cfg_ff.orientation <= 3'd0;
         cfg_ff.locked      <= 1'b0;
      end else if (csr_write) begin
         unique case (reg_sel)
            trd_pkg::REG_CAL_MIN_X:   cfg_ff.cal_min_x   <= csr_pwdata[7:0];
            trd_pkg::REG_CAL_MIN_Y:   cfg_ff.cal_min_y   <= csr_pwdata[7:0];
            trd_pkg::REG_CAL_MAX_X:   cfg_ff.cal_max_x   <= csr_pwdata[7:0];
            trd_pkg::REG_CAL_MAX_Y:   cfg_ff.cal_max_y   <= csr_pwdata[7:0];
            trd_pkg::REG_ORIENTATION: cfg_ff.orientation <= csr_pwdata[2:0];
            trd_pkg::REG_LOCKED:      cfg_ff.locked      <= csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   // Read back; addresses past the register list read as zero.
   always_comb begin
      unique case (reg_sel)
         trd_pkg::REG_CAL_MIN_X:   csr_prdata = {24'd0, cfg_ff.cal_min_x};
         trd_pkg::REG_CAL_MIN_Y:   csr_prdata = {24'd0, cfg_ff.cal_min_y};
         trd_pkg::REG_CAL_MAX_X:   csr_prdata = {24'd0, cfg_ff.cal_max_x};
         trd_pkg::REG_CAL_MAX_Y:   csr_prdata = {24'd0, cfg_ff.cal_max_y};
         trd_pkg::REG_ORIENTATION: csr_prdata = {29'd0, cfg_ff.orientation};
         trd_pkg::REG_LOCKED:      csr_prdata = {31'd0, cfg_ff.locked};
         default:                  csr_prdata = 32'd0;
      endcase
   end

   trd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   trd_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cfg              (cfg_ff),
      .cmd              (cmd),
      .status           (status),
      .req_gesture_code (req_gesture_code),
      .req_touch_points (req_touch_points),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .rsp_swipe_valid  (rsp_swipe_valid),
      .rsp_swipe_dx     (rsp_swipe_dx),
      .rsp_swipe_dy     (rsp_swipe_dy),
      .rsp_tap_left     (rsp_tap_left),
      .rsp_tap_right    (rsp_tap_right),
      .rsp_tap_kind     (rsp_tap_kind),
      .rsp_drag_valid   (rsp_drag_valid),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pressed      (rsp_pressed),
      .rsp_drag_dx      (rsp_drag_dx),
      .rsp_drag_dy      (rsp_drag_dy)
   );

endmodule

[bench/touch_report_event_decoder_test.sv]
// Self-checking testbench for touch_report_event_decoder: report beats in, event beats out.
// Depends on trd_pkg and the decoder RTL; it predicts each event and checks it field by field.
module touch_report_event_decoder_test;

   // The drain wait gives the decoder time after the last event beat, so that no
   // report is still in flight when the registers are rewritten.
   localparam int DRAIN_CYCLES   = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int HOLD_CYCLES    = 300;
   localparam int PHASE_REPORTS  = 55;

   // One report from the touch controller, as it travels on the input channel.
   typedef struct {
      logic [7:0] gesture;
      logic [7:0] touch;
      logic [7:0] raw_x;
      logic [7:0] raw_y;
   } report_type;

   // One decoded event, as it travels on the result channel.
   typedef struct {
      logic              swipe_valid;
      logic signed [1:0] swipe_dx;
      logic signed [1:0] swipe_dy;
      logic              tap_left;
      logic              tap_right;
      logic [1:0]        tap_kind;
      logic              drag_valid;
      logic [7:0]        pos_x;
      logic [7:0]        pos_y;
      logic              pressed;
      logic signed [8:0] drag_dx;
      logic signed [8:0] drag_dy;
   } touch_event_type;

   logic              clock;
   logic              reset;
   logic              req_valid;
   logic              req_ready;
   logic [7:0]        req_gesture_code;
   logic [7:0]        req_touch_points;
   logic [7:0]        req_raw_x;
   logic [7:0]        req_raw_y;
   logic              rsp_valid;
   logic              rsp_ready;
   logic              rsp_swipe_valid;
   logic signed [1:0] rsp_swipe_dx;
   logic signed [1:0] rsp_swipe_dy;
   logic              rsp_tap_left;
   logic              rsp_tap_right;
   logic [1:0]        rsp_tap_kind;
   logic              rsp_drag_valid;
   logic [7:0]        rsp_pos_x;
   logic [7:0]        rsp_pos_y;
   logic              rsp_pressed;
   logic signed [8:0] rsp_drag_dx;
   logic signed [8:0] rsp_drag_dy;
   logic              csr_psel;
   logic              csr_penable;
   logic              csr_pwrite;
   logic [trd_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [31:0]       csr_pwdata;
   logic [31:0]       csr_prdata;
   logic              csr_pready;

   touch_report_event_decoder DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_gesture_code (req_gesture_code),
      .req_touch_points (req_touch_points),
      .req_raw_x        (req_raw_x),
      .req_raw_y        (req_raw_y),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_swipe_valid  (rsp_swipe_valid),
      .rsp_swipe_dx     (rsp_swipe_dx),
      .rsp_swipe_dy     (rsp_swipe_dy),
      .rsp_tap_left     (rsp_tap_left),
      .rsp_tap_right    (rsp_tap_right),
      .rsp_tap_kind     (rsp_tap_kind),
      .rsp_drag_valid   (rsp_drag_valid),
      .rsp_pos_x        (rsp_pos_x),
      .rsp_pos_y        (rsp_pos_y),
      .rsp_pressed      (rsp_pressed),
      .rsp_drag_dx      (rsp_drag_dx),
      .rsp_drag_dy      (rsp_drag_dy),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Our own copy of the register file and of the decoder's history. The
   // history moves forward when a report beat is accepted, so the events
   // are predicted in the same order in which the decoder produces them.
   trd_pkg::cfg_type settings_q;
   logic [7:0]       hist_gesture;
   logic [7:0]       hist_x;
   logic [7:0]       hist_y;
   logic             hist_pressed;

   touch_event_type pending_events[$];
   report_type      last_sent;
   int              mismatch_count;
   int              send_idle_pct;
   int              recv_idle_pct;
   int              hold_left;
   int              stall_cycles;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Event prediction
   // ---------------------------------------------------------------------

   // Linear map from the calibration window to the screen. Raw bytes of 250
   // or more count as zero, and a window of zero width gives zero. SV integer
   // division truncates toward zero, which is the rounding that we want here.
   function automatic int scale_axis(logic [7:0] raw, logic [7:0] lo, logic [7:0] hi,
                                     int size);
      int r;
      int span;
      r    = (raw >= trd_pkg::RAW_LIMIT) ? 0 : int'(raw);
      span = int'(hi) - int'(lo);
      if (span == 0)
         return 0;
      return ((r - int'(lo)) * size) / span;
   endfunction

   function automatic logic [7:0] saturate(int v, int size);
      if (v < 0)
         return 8'd0;
      if (v > size - 1)
         return 8'(size - 1);
      return 8'(v);
   endfunction

   function automatic touch_event_type decode_report(report_type rep);
      touch_event_type ev;
      int x;
      int y;
      int t;
      int sdx;
      int sdy;
      logic is_tap;
      ev = '{default: '0};
      sdx = 0;
      sdy = 0;
      is_tap = 1'b0;
      // While locked, the event is all zeros and the history stays as it was.
      if (settings_q.locked)
         return ev;

      x = scale_axis(rep.raw_x, settings_q.cal_min_x, settings_q.cal_max_x,
                     trd_pkg::SCREEN_WIDTH);
      y = scale_axis(rep.raw_y, settings_q.cal_min_y, settings_q.cal_max_y,
                     trd_pkg::SCREEN_HEIGHT);
      if (settings_q.orientation[0])
         x = trd_pkg::SCREEN_WIDTH - 1 - x;
      if (settings_q.orientation[1])
         y = trd_pkg::SCREEN_HEIGHT - 1 - y;
      if (settings_q.orientation[2]) begin
         t = x;
         x = y;
         y = t;
      end
      ev.pos_x   = saturate(x, trd_pkg::SCREEN_WIDTH);
      ev.pos_y   = saturate(y, trd_pkg::SCREEN_HEIGHT);
      ev.pressed = (rep.touch != 8'd0);

      // Only a change of gesture code is an event. Unknown codes and zero
      // give nothing, but they still become the remembered code.
      if (rep.gesture != hist_gesture) begin
         case (rep.gesture)
            trd_pkg::GEST_DOWN:   sdy = 1;
            trd_pkg::GEST_UP:     sdy = -1;
            trd_pkg::GEST_LEFT:   sdx = -1;
            trd_pkg::GEST_RIGHT:  sdx = 1;
            trd_pkg::GEST_CLICK: begin
               is_tap      = 1'b1;
               ev.tap_kind = trd_pkg::TAP_CLICK;
            end
            trd_pkg::GEST_DOUBLE: begin
               is_tap      = 1'b1;
               ev.tap_kind = trd_pkg::TAP_DOUBLE;
            end
            trd_pkg::GEST_LONG: begin
               is_tap      = 1'b1;
               ev.tap_kind = trd_pkg::TAP_LONG;
            end
            default: ;
         endcase
         if (sdx != 0 || sdy != 0) begin
            // The swipe direction turns with the screen, like the position.
            ev.swipe_valid = 1'b1;
            if (settings_q.orientation[0])
               sdx = -sdx;
            if (settings_q.orientation[1])
               sdy = -sdy;
            if (settings_q.orientation[2]) begin
               t   = sdx;
               sdx = sdy;
               sdy = t;
            end
         end
         if (is_tap) begin
            ev.tap_left  = (ev.pos_x < trd_pkg::TAP_SPLIT);
            ev.tap_right = !ev.tap_left;
         end
      end
      hist_gesture = rep.gesture;
      ev.swipe_dx  = 2'(sdx);
      ev.swipe_dy  = 2'(sdy);

      // A drag is reported when the press state or the position moved since
      // the last drag. It carries a delta only if the finger was down then.
      if (ev.pressed != hist_pressed || ev.pos_x != hist_x || ev.pos_y != hist_y) begin
         ev.drag_valid = 1'b1;
         if (hist_pressed) begin
            ev.drag_dx = 9'(int'(ev.pos_x) - int'(hist_x));
            ev.drag_dy = 9'(int'(ev.pos_y) - int'(hist_y));
         end
         hist_x       = ev.pos_x;
         hist_y       = ev.pos_y;
         hist_pressed = ev.pressed;
      end
      return ev;
   endfunction

   // ---------------------------------------------------------------------
   // Result checking
   // ---------------------------------------------------------------------

   task automatic compare_field(string label, int want, int got);
      if (want != got) begin
         $display("%0t: %s expected %0d, got %0d", $time, label, want, got);
         mismatch_count++;
      end
   endtask

   // Every result beat is matched against the oldest outstanding prediction.
   always @(posedge clock) begin : check_events
      touch_event_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_events.size() == 0) begin
            $display("%0t: event beat arrived with no report outstanding", $time);
            mismatch_count++;
         end else begin
            want = pending_events.pop_front();
            compare_field("swipe_valid", want.swipe_valid, rsp_swipe_valid);
            compare_field("swipe_dx", want.swipe_dx, rsp_swipe_dx);
            compare_field("swipe_dy", want.swipe_dy, rsp_swipe_dy);
            compare_field("tap_left", want.tap_left, rsp_tap_left);
            compare_field("tap_right", want.tap_right, rsp_tap_right);
            compare_field("tap_kind", want.tap_kind, rsp_tap_kind);
            compare_field("drag_valid", want.drag_valid, rsp_drag_valid);
            compare_field("pos_x", want.pos_x, rsp_pos_x);
            compare_field("pos_y", want.pos_y, rsp_pos_y);
            compare_field("pressed", want.pressed, rsp_pressed);
            compare_field("drag_dx", want.drag_dx, rsp_drag_dx);
            compare_field("drag_dy", want.drag_dy, rsp_drag_dy);
         end
      end
   end

   // The watchdog ends a run that stops moving. Register accesses, the drain
   // wait and the long receiver hold all fit well inside the limit.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles == WATCHDOG_LIMIT) begin
         $display("%0t: no beat moved for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("touch_report_event_decoder_test NOT OK");
         $finish;
      end
   end

   // The receiver takes event beats at random, or holds off entirely while a
   // test has asked for a long stall.
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            rsp_ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // ---------------------------------------------------------------------
   // Report sender and register port
   // ---------------------------------------------------------------------

   // Offers one report beat and holds it until it is taken. Valid stays high
   // after acceptance, so the next call either puts a new report on the same
   // falling edge or lowers valid there for an idle cycle.
   task automatic send_report(report_type rep);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid        = 1'b1;
      req_gesture_code = rep.gesture;
      req_touch_points = rep.touch;
      req_raw_x        = rep.raw_x;
      req_raw_y        = rep.raw_y;
      do @(posedge clock); while (!req_ready);
      pending_events.push_back(decode_report(rep));
   endtask

   // Lowers valid, waits for every outstanding event beat, then gives the
   // decoder time to settle before the registers are touched.
   task automatic wait_idle();
      @(negedge clock);
      req_valid = 1'b0;
      while (pending_events.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // One bus transfer: a setup cycle, then an access cycle that completes at
   // the rising edge where pready is high.
   task automatic csr_access(input logic write, input trd_pkg::reg_index_type idx,
                             input logic [31:0] data, output logic [31:0] rdata);
      @(negedge clock);
      csr_psel    = 1'b1;
      csr_penable = 1'b0;
      csr_pwrite  = write;
      csr_paddr   = {idx, 2'b00};
      csr_pwdata  = data;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   function automatic logic [31:0] register_value(trd_pkg::reg_index_type idx);
      case (idx)
         trd_pkg::REG_CAL_MIN_X:   return 32'(settings_q.cal_min_x);
         trd_pkg::REG_CAL_MIN_Y:   return 32'(settings_q.cal_min_y);
         trd_pkg::REG_CAL_MAX_X:   return 32'(settings_q.cal_max_x);
         trd_pkg::REG_CAL_MAX_Y:   return 32'(settings_q.cal_max_y);
         trd_pkg::REG_ORIENTATION: return 32'(settings_q.orientation);
         default:                  return 32'(settings_q.locked);
      endcase
   endfunction

   task automatic check_register(trd_pkg::reg_index_type idx);
      logic [31:0] value;
      csr_access(1'b0, idx, 32'd0, value);
      if (value !== register_value(idx)) begin
         $display("%0t: register %s expected %0d, got %0d", $time, idx.name(),
                  register_value(idx), value);
         mismatch_count++;
      end
   endtask

   task automatic write_register(trd_pkg::reg_index_type idx, logic [31:0] data);
      logic [31:0] unused;
      csr_access(1'b1, idx, data, unused);
      case (idx)
         trd_pkg::REG_CAL_MIN_X:   settings_q.cal_min_x   = data[7:0];
         trd_pkg::REG_CAL_MIN_Y:   settings_q.cal_min_y   = data[7:0];
         trd_pkg::REG_CAL_MAX_X:   settings_q.cal_max_x   = data[7:0];
         trd_pkg::REG_CAL_MAX_Y:   settings_q.cal_max_y   = data[7:0];
         trd_pkg::REG_ORIENTATION: settings_q.orientation = data[2:0];
         default:                  settings_q.locked      = data[0];
      endcase
      check_register(idx);
   endtask

   // Rewrites the whole register file once the decoder has gone idle.
   task automatic apply_settings(logic [7:0] min_x, logic [7:0] min_y, logic [7:0] max_x,
                                 logic [7:0] max_y, logic [2:0] orient, logic lock);
      wait_idle();
      write_register(trd_pkg::REG_CAL_MIN_X, 32'(min_x));
      write_register(trd_pkg::REG_CAL_MIN_Y, 32'(min_y));
      write_register(trd_pkg::REG_CAL_MAX_X, 32'(max_x));
      write_register(trd_pkg::REG_CAL_MAX_Y, 32'(max_y));
      write_register(trd_pkg::REG_ORIENTATION, 32'(orient));
      write_register(trd_pkg::REG_LOCKED, 32'(lock));
   endtask

   // ---------------------------------------------------------------------
   // Random reports
   // ---------------------------------------------------------------------

   function automatic logic [7:0] known_gesture(int k);
      case (k)
         1:       return trd_pkg::GEST_DOWN;
         2:       return trd_pkg::GEST_UP;
         3:       return trd_pkg::GEST_LEFT;
         4:       return trd_pkg::GEST_RIGHT;
         5:       return trd_pkg::GEST_CLICK;
         6:       return trd_pkg::GEST_DOUBLE;
         7:       return trd_pkg::GEST_LONG;
         default: return 8'h00;
      endcase
   endfunction

   // Most coordinates fall inside the calibration window; the rest cover the
   // full byte range and the band that the decoder forces to zero.
   function automatic logic [7:0] random_raw(logic [7:0] lo, logic [7:0] hi);
      int pick = $urandom_range(99);
      if (pick < 70)
         return 8'($urandom_range(lo, hi));
      if (pick < 85)
         return 8'($urandom_range(255, 0));
      return 8'($urandom_range(255, 250));
   endfunction

   // Reports look like real controller traffic: gestures mostly from the
   // known set, often repeated, and positions that sometimes stay put so
   // that reports without a drag come up as well.
   function automatic report_type random_report();
      report_type rep;
      int pick;
      rep  = last_sent;
      pick = $urandom_range(99);
      if (pick >= 85)
         rep.gesture = 8'($urandom_range(255, 0));
      else if (pick >= 25)
         rep.gesture = known_gesture($urandom_range(7, 0));
      if ($urandom_range(99) >= 20) begin
         pick = $urandom_range(99);
         if (pick < 40)
            rep.touch = 8'd0;
         else if (pick < 85)
            rep.touch = 8'($urandom_range(5, 1));
         else
            rep.touch = 8'($urandom_range(255, 1));
         rep.raw_x = random_raw(settings_q.cal_min_x, settings_q.cal_max_x);
         rep.raw_y = random_raw(settings_q.cal_min_y, settings_q.cal_max_y);
      end
      last_sent = rep;
      return rep;
   endfunction

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Every register must read back its reset value.
   task automatic test_register_reset();
      trd_pkg::reg_index_type idx;
      idx = idx.first();
      do begin
         check_register(idx);
         idx = idx.next();
      end while (idx != idx.first());
   endtask

   // Hand-picked reports under the reset calibration (0..160 maps onto 176
   // pixels, no rotation): field extremes, every gesture, repeats of a code,
   // unknown codes, the tap split at column 80 and drags in both directions.
   task automatic test_directed_reports();
      send_report('{8'h00, 8'd0, 8'd0, 8'd0});      // matches reset history: quiet
      send_report('{trd_pkg::GEST_DOWN, 8'd1, 8'd0, 8'd0});  // swipe down, press starts
      send_report('{trd_pkg::GEST_DOWN, 8'd1, 8'd80, 8'd40}); // same code: drag only
      send_report('{trd_pkg::GEST_UP, 8'd1, 8'd160, 8'd160}); // right and bottom edges
      send_report('{trd_pkg::GEST_LEFT, 8'd1, 8'd255, 8'd249}); // 255 reads as zero
      send_report('{trd_pkg::GEST_RIGHT, 8'd0, 8'd250, 8'd0}); // release
      send_report('{trd_pkg::GEST_CLICK, 8'd1, 8'd10, 8'd10}); // tap on the left
      send_report('{trd_pkg::GEST_CLICK, 8'd1, 8'd10, 8'd10}); // identical: no event
      send_report('{trd_pkg::GEST_DOUBLE, 8'd1, 8'd73, 8'd5}); // lands on column 80
      send_report('{trd_pkg::GEST_LONG, 8'd1, 8'd72, 8'd5});  // column 79
      send_report('{8'h06, 8'd1, 8'd72, 8'd5});      // unknown code
      send_report('{8'hFF, 8'hFF, 8'd0, 8'd0});
      send_report('{8'hFF, 8'hFF, 8'd0, 8'd0});
      send_report('{8'h00, 8'h80, 8'd159, 8'd1});    // back to code zero
      send_report('{trd_pkg::GEST_CLICK, 8'd0, 8'd200, 8'd100}); // tap on the right
      send_report('{8'hAA, 8'h55, 8'h55, 8'hAA});
      send_report('{8'h55, 8'hAA, 8'hAA, 8'h55});
      send_report('{trd_pkg::GEST_LONG, 8'd2, 8'd100, 8'd150});
      send_report('{trd_pkg::GEST_DOUBLE, 8'd3, 8'd30, 8'd20}); // drag toward the origin
   endtask

   // Each orientation with all four swipes, a tap and a drag.
   task automatic test_orientation_rotation();
      for (int o = 0; o < 8; o++) begin
         apply_settings(8'd0, 8'd0, 8'd160, 8'd160, 3'(o), 1'b0);
         send_report('{trd_pkg::GEST_DOWN, 8'd1, 8'd20, 8'd140});
         send_report('{trd_pkg::GEST_UP, 8'd1, 8'd40, 8'd120});
         send_report('{trd_pkg::GEST_LEFT, 8'd1, 8'd60, 8'd100});
         send_report('{trd_pkg::GEST_RIGHT, 8'd1, 8'd140, 8'd20});
         send_report('{trd_pkg::GEST_CLICK, 8'd1, 8'd20, 8'd140});
         send_report('{8'h00, 8'd0, 8'd140, 8'd20});
      end
   endtask

   // Zero-width windows, a reversed window and a one-step window that makes
   // every raw value from 1 to 249 overshoot the screen.
   task automatic test_calibration_edges();
      apply_settings(8'd100, 8'd0, 8'd100, 8'd0, 3'd0, 1'b0);
      repeat (4) send_report(random_report());
      apply_settings(8'd200, 8'd50, 8'd50, 8'd200, 3'd3, 1'b0);
      repeat (4) send_report(random_report());
      apply_settings(8'd0, 8'd0, 8'd1, 8'd1, 3'd5, 1'b0);
      repeat (4) send_report(random_report());
   endtask

   // Locked reports give all-zero events and leave the history alone, which
   // the first reports after unlocking show.
   task automatic test_lock();
      apply_settings(8'd0, 8'd0, 8'd160, 8'd160, 3'd0, 1'b0);
      send_report('{trd_pkg::GEST_DOWN, 8'd1, 8'd50, 8'd50});
      apply_settings(8'd0, 8'd0, 8'd160, 8'd160, 3'd0, 1'b1);
      send_report('{trd_pkg::GEST_UP, 8'd1, 8'd90, 8'd90});
      send_report('{trd_pkg::GEST_CLICK, 8'd0, 8'd10, 8'd150});
      repeat (4) send_report(random_report());
      apply_settings(8'd0, 8'd0, 8'd160, 8'd160, 3'd0, 1'b0);
      send_report('{trd_pkg::GEST_DOWN, 8'd1, 8'd60, 8'd50});
      send_report('{trd_pkg::GEST_UP, 8'd1, 8'd60, 8'd50});
   endtask

   // The receiver stalls for a long stretch while the sender keeps offering
   // reports back to back, so the decoder fills up and stops taking beats.
   task automatic test_backpressure();
      int saved_pct;
      saved_pct = send_idle_pct;
      wait_idle();
      send_idle_pct = 0;
      hold_left     = HOLD_CYCLES;
      repeat (16) send_report(random_report());
      send_idle_pct = saved_pct;
   endtask

   // Random traffic under three idling patterns, each over four register
   // settings: random, the widest window, a fully reversed window, and a
   // random one that sometimes has zero width or is locked.
   task automatic test_random_traffic();
      for (int mode = 0; mode < 3; mode++) begin
         case (mode)
            0: begin
               send_idle_pct = 36;
               recv_idle_pct = 55;
            end
            1: begin
               send_idle_pct = 55;
               recv_idle_pct = 36;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int ph = 0; ph < 4; ph++) begin
            case (ph)
               0: apply_settings(8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                 8'($urandom_range(255, 0)), 8'($urandom_range(255, 0)),
                                 3'($urandom_range(7, 0)), 1'b0);
               1: apply_settings(8'd0, 8'd0, 8'd255, 8'd255, 3'd7, 1'b0);
               2: apply_settings(8'd255, 8'd255, 8'd0, 8'd0, 3'($urandom_range(7, 0)),
                                 1'b0);
               default: begin
                  logic [7:0] lo;
                  lo = 8'($urandom_range(120, 0));
                  apply_settings(lo, 8'($urandom_range(120, 0)),
                                 ($urandom_range(3, 0) == 0) ? lo
                                                             : 8'($urandom_range(255, 121)),
                                 8'($urandom_range(255, 121)), 3'($urandom_range(7, 0)),
                                 $urandom_range(5, 0) == 0);
               end
            endcase
            repeat (PHASE_REPORTS) send_report(random_report());
         end
      end
   endtask

   // ---------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------

   initial begin
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_gesture_code = 8'd0;
      req_touch_points = 8'd0;
      req_raw_x        = 8'd0;
      req_raw_y        = 8'd0;
      csr_psel         = 1'b0;
      csr_penable      = 1'b0;
      csr_pwrite       = 1'b0;
      csr_paddr        = '0;
      csr_pwdata       = 32'd0;
      mismatch_count   = 0;
      stall_cycles     = 0;
      hold_left        = 0;
      send_idle_pct    = 36;
      recv_idle_pct    = 55;
      last_sent        = '{8'd0, 8'd0, 8'd0, 8'd0};

      settings_q              = '0;
      settings_q.cal_max_x    = trd_pkg::CAL_MAX_RESET;
      settings_q.cal_max_y    = trd_pkg::CAL_MAX_RESET;
      hist_gesture            = 8'd0;
      hist_x                  = 8'd0;
      hist_y                  = 8'd0;
      hist_pressed            = 1'b0;

      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_register_reset();
      test_directed_reports();
      test_orientation_rotation();
      test_calibration_edges();
      test_lock();
      test_backpressure();
      test_random_traffic();
      wait_idle();

      if (mismatch_count == 0)
         $display("touch_report_event_decoder_test OK");
      else
         $display("touch_report_event_decoder_test NOT OK");
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/trd_pkg.sv
sv/trd_ctrl.sv
sv/trd_dp.sv
sv/touch_report_event_decoder.sv
bench/touch_report_event_decoder_test.sv
